@@ src/pfd_pkg.sv @@
package pfd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned ValueW    = 16;
  localparam int unsigned NumValues = 6;
  localparam int unsigned StoreDepth = 12;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned OutDataW  = ValueW * NumValues;

  localparam logic [ByteW-1:0] SyncA = 8'hAA;
  localparam logic [ByteW-1:0] SyncB = 8'hAB;
  localparam logic [ByteW-1:0] SyncC = 8'hBB;

  // index of the trailing payload byte, which closes the frame
  localparam logic [IdxW-1:0] LastIdx = IdxW'(StoreDepth);

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhHdr2 = 2'd1,
    PhHdr3 = 2'd2,
    PhData = 2'd3
  } phase_e;

  typedef struct packed {
    logic signed [ValueW-1:0] z_tenths;
    logic signed [ValueW-1:0] altitude_hundredths;
    logic signed [ValueW-1:0] x_position;
    logic signed [ValueW-1:0] yaw_halves;
    logic signed [ValueW-1:0] pitch_tenths;
    logic signed [ValueW-1:0] roll_tenths;
  } pose_t;

endpackage

@@ src/pfd_parser.sv @@
module pfd_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 byte_valid_i,
  input  logic [pfd_pkg::ByteW-1:0] byte_i,
  output logic                 frame_valid_o,
  output pfd_pkg::pose_t       pose_o
);
  import pfd_pkg::*;

  phase_e          phase_q, phase_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            hdr_ok_q, hdr_ok_d;
  logic [ByteW-1:0] store_q [StoreDepth];
  logic            store_we;

  always_comb begin
    phase_d       = phase_q;
    idx_d         = idx_q;
    hdr_ok_d      = hdr_ok_q;
    store_we      = 1'b0;
    frame_valid_o = 1'b0;
    if (byte_valid_i) begin
      unique case (phase_q)
        PhIdle: begin
          if (byte_i == SyncA) phase_d = PhHdr2;
        end
        PhHdr2: begin
          hdr_ok_d = (byte_i == SyncB);
          phase_d  = PhHdr3;
        end
        PhHdr3: begin
          // drop both header bytes on a mismatch
          if (hdr_ok_q && byte_i == SyncC) begin
            phase_d = PhData;
            idx_d   = '0;
          end else begin
            phase_d = PhIdle;
          end
          hdr_ok_d = 1'b0;
        end
        PhData: begin
          if (idx_q == LastIdx) begin
            frame_valid_o = 1'b1;
            phase_d       = PhIdle;
            idx_d         = '0;
          end else begin
            store_we = 1'b1;
            idx_d    = idx_q + 1'b1;
          end
        end
        default: phase_d = PhIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      idx_q    <= '0;
      hdr_ok_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      hdr_ok_q <= hdr_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) store_q[idx_q] <= byte_i;
  end

  // high byte first
  assign pose_o.roll_tenths         = {store_q[0],  store_q[1]};
  assign pose_o.pitch_tenths        = {store_q[2],  store_q[3]};
  assign pose_o.yaw_halves          = {store_q[4],  store_q[5]};
  assign pose_o.x_position          = {store_q[6],  store_q[7]};
  assign pose_o.altitude_hundredths = {store_q[8],  store_q[9]};
  assign pose_o.z_tenths            = {store_q[10], store_q[11]};

endmodule

@@ src/pose_frame_deframer_unit.sv @@
// Pose frame deframer: takes one received byte per word and finds frames of the
// form AA AB BB followed by 13 payload bytes. The first twelve payload bytes are six
// signed 16-bit big-endian values, passed out unscaled as one output word when the
// thirteenth byte arrives. A bad second or third header byte drops both and the
// search restarts on the byte after the third header byte. One input byte is taken
// every cycle in which the input does not stall, and the output word is valid the
// cycle after the thirteenth payload byte is accepted. The input stalls in every cycle
// in which the output register holds a word that the receiver does not take, whichever
// byte is waiting; with the receiver ready there is no stall.
module pose_frame_deframer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // [7:0] rx_byte
  input  logic [pfd_pkg::ByteW-1:0]    s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [15:0] roll_tenths, [31:16] pitch_tenths, [47:32] yaw_halves,
  // [63:48] x_position, [79:64] altitude_hundredths, [95:80] z_tenths
  output logic [pfd_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import pfd_pkg::*;

  logic  byte_acc;
  logic  frame_valid;
  pose_t pose;
  logic  out_valid_q, out_valid_d;
  pose_t out_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign byte_acc        = s_axis_tvalid_i && s_axis_tready_o;

  pfd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_acc),
    .byte_i       (s_axis_tdata_i),
    .frame_valid_o(frame_valid),
    .pose_o       (pose)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) out_valid_d = 1'b0;
    if (frame_valid) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_valid) out_q <= pose;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule
